### rtl/core/atc_pkg.sv
// Package with the types, constants and tables of the affine transform composer.
`default_nettype none
package atc_pkg;

   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int CNT_BITS     = 5;

   localparam logic [2:0] KIND_IDENT     = 3'd0;
   localparam logic [2:0] KIND_SCALE     = 3'd1;
   localparam logic [2:0] KIND_ROTATE    = 3'd2;
   localparam logic [2:0] KIND_TRANSLATE = 3'd3;
   localparam logic [2:0] KIND_MULT      = 3'd4;

   localparam logic [CNT_BITS-1:0] RED_LAST    = CNT_BITS'(7);
   localparam logic [CNT_BITS-1:0] CORDIC_LAST = CNT_BITS'(CORDIC_STEPS - 1);
   localparam logic [CNT_BITS-1:0] MULT_LAST   = CNT_BITS'(12);

   localparam logic signed [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1 << FRAC_BITS);

   // Angles are in degrees with 16 fraction bits.
   localparam logic [33:0] DEG360_Q16 = 34'd23592960;
   localparam logic [33:0] DEG90_Q16  = 34'd5898240;
   localparam logic [33:0] RED_BIAS   = 34'd3019898880;
   localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

   typedef struct packed {
      logic [2:0]                  kind;
      logic signed [WORD_BITS-1:0] x_value;
      logic signed [WORD_BITS-1:0] y_value;
      logic signed [WORD_BITS-1:0] angle_deg;
      logic signed [WORD_BITS-1:0] mul_00;
      logic signed [WORD_BITS-1:0] mul_01;
      logic signed [WORD_BITS-1:0] mul_02;
      logic signed [WORD_BITS-1:0] mul_10;
      logic signed [WORD_BITS-1:0] mul_11;
      logic signed [WORD_BITS-1:0] mul_12;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_00;
      logic signed [WORD_BITS-1:0] out_01;
      logic signed [WORD_BITS-1:0] out_02;
      logic signed [WORD_BITS-1:0] out_10;
      logic signed [WORD_BITS-1:0] out_11;
      logic signed [WORD_BITS-1:0] out_12;
      logic                        scale_or_rotate;
   } rsp_type;

   typedef struct packed {
      logic                load;
      logic                red_step;
      logic                quad;
      logic                cordic_step;
      logic                sincos;
      logic                mult;
      logic                commit;
      logic [CNT_BITS-1:0] cnt;
   } ctl_cmd_type;

   function automatic logic signed [24:0] atan_deg(input logic [CNT_BITS-1:0] i);
      logic signed [24:0] v;
      case (i)
         5'd0:    v = 25'sd2949120;
         5'd1:    v = 25'sd1740967;
         5'd2:    v = 25'sd919879;
         5'd3:    v = 25'sd466945;
         5'd4:    v = 25'sd234379;
         5'd5:    v = 25'sd117305;
         5'd6:    v = 25'sd58666;
         5'd7:    v = 25'sd29335;
         5'd8:    v = 25'sd14668;
         5'd9:    v = 25'sd7334;
         5'd10:   v = 25'sd3667;
         5'd11:   v = 25'sd1833;
         5'd12:   v = 25'sd917;
         5'd13:   v = 25'sd458;
         5'd14:   v = 25'sd229;
         5'd15:   v = 25'sd115;
         5'd16:   v = 25'sd57;
         5'd17:   v = 25'sd29;
         5'd18:   v = 25'sd14;
         5'd19:   v = 25'sd7;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/core/atc_ctrl.sv
// Sequencer of the affine transform composer: one command at a time.
`default_nettype none
module atc_ctrl
   import atc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [2:0]  req_kind,
   input  wire logic        out_free,
   output ctl_cmd_type      cmd,
   output logic             idle,
   output logic             done
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_REDUCE = 8'b0000_0010,
      ST_QUAD   = 8'b0000_0100,
      ST_CORDIC = 8'b0000_1000,
      ST_SINCOS = 8'b0001_0000,
      ST_MULT   = 8'b0010_0000,
      ST_COMMIT = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.cnt  = cnt_ff;
      idle     = 1'b0;
      done     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               if (req_kind == KIND_ROTATE) begin
                  state_in = ST_REDUCE;
               end else if (req_kind == KIND_SCALE || req_kind == KIND_TRANSLATE ||
                            req_kind == KIND_MULT) begin
                  state_in = ST_MULT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == RED_LAST) begin
               cnt_in   = '0;
               state_in = ST_QUAD;
            end
         end
         ST_QUAD: begin
            cmd.quad = 1'b1;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CORDIC_LAST) begin
               cnt_in   = '0;
               state_in = ST_SINCOS;
            end
         end
         ST_SINCOS: begin
            cmd.sincos = 1'b1;
            state_in   = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MULT_LAST) begin
               cnt_in   = '0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/atc_datapath.sv
// Datapath: angle reduction, CORDIC, shared multiplier and the running matrix.
`default_nettype none
module atc_datapath
   import atc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_cmd_type cmd,
   input  wire req_type     req_data,
   output rsp_type          result
);

   logic signed [WORD_BITS-1:0] m_ff [6];
   logic signed [WORD_BITS-1:0] n_ff [6];
   logic signed [WORD_BITS-1:0] b_ff [6];
   logic [33:0]                 r_ff;
   logic [1:0]                  q_ff;
   logic signed [24:0]          z_ff;
   logic signed [32:0]          x_ff, y_ff;
   logic signed [63:0]          prod_ff;
   logic signed [65:0]          acc_ff;

   // Operand matrix of a command that does not rotate; identity for the rest.
   logic signed [WORD_BITS-1:0] b_load [6];
   always_comb begin
      b_load[0] = ONE_Q;
      b_load[1] = '0;
      b_load[2] = '0;
      b_load[3] = '0;
      b_load[4] = ONE_Q;
      b_load[5] = '0;
      case (req_data.kind)
         KIND_SCALE: begin
            b_load[0] = req_data.x_value;
            b_load[4] = req_data.y_value;
         end
         KIND_TRANSLATE: begin
            b_load[2] = req_data.x_value;
            b_load[5] = req_data.y_value;
         end
         KIND_MULT: begin
            b_load[0] = req_data.mul_00;
            b_load[1] = req_data.mul_01;
            b_load[2] = req_data.mul_02;
            b_load[3] = req_data.mul_10;
            b_load[4] = req_data.mul_11;
            b_load[5] = req_data.mul_12;
         end
         default: begin
         end
      endcase
   end

   // Reduction step: subtract 360 degrees times a falling power of two.
   logic [2:0]  red_k;
   logic [33:0] red_sub;
   assign red_k   = 3'd7 - cmd.cnt[2:0];
   assign red_sub = DEG360_Q16 << red_k;

   // Quadrant of the reduced angle.
   logic [1:0]  quad_q;
   logic [33:0] quad_base;
   always_comb begin
      if (r_ff >= 34'(3) * DEG90_Q16) begin
         quad_q = 2'd3;
      end else if (r_ff >= 34'(2) * DEG90_Q16) begin
         quad_q = 2'd2;
      end else if (r_ff >= DEG90_Q16) begin
         quad_q = 2'd1;
      end else begin
         quad_q = 2'd0;
      end
      quad_base = DEG90_Q16 * 34'(quad_q);
   end

   // CORDIC rotation step.
   logic signed [32:0] cor_dx, cor_dy;
   logic signed [24:0] cor_atan;
   assign cor_dx   = y_ff >>> cmd.cnt;
   assign cor_dy   = x_ff >>> cmd.cnt;
   assign cor_atan = atan_deg(cmd.cnt);

   // Round cosine and sine to the output fraction, clamp, map the quadrant.
   logic signed [32:0]          cos_r, sin_r;
   logic signed [WORD_BITS-1:0] cos_c, sin_c, rot_c, rot_s;
   always_comb begin
      cos_r = (x_ff + 33'sd8192) >>> 14;
      sin_r = (y_ff + 33'sd8192) >>> 14;
      if (cos_r > 33'(ONE_Q)) begin
         cos_c = ONE_Q;
      end else if (cos_r < -33'(ONE_Q)) begin
         cos_c = -ONE_Q;
      end else begin
         cos_c = WORD_BITS'(cos_r);
      end
      if (sin_r > 33'(ONE_Q)) begin
         sin_c = ONE_Q;
      end else if (sin_r < -33'(ONE_Q)) begin
         sin_c = -ONE_Q;
      end else begin
         sin_c = WORD_BITS'(sin_r);
      end
      case (q_ff)
         2'd0:    begin rot_c = cos_c;  rot_s = sin_c;  end
         2'd1:    begin rot_c = -sin_c; rot_s = cos_c;  end
         2'd2:    begin rot_c = -cos_c; rot_s = -sin_c; end
         default: begin rot_c = sin_c;  rot_s = -cos_c; end
      endcase
   end

   // Product sequence: step s forms term s[0] of entry s[3:1]; the
   // product of each step is registered in prod_ff and accumulated in the next step.
   logic [3:0]                  mul_s, acc_s;
   logic [2:0]                  mul_e, acc_e;
   logic [1:0]                  mul_col, acc_col;
   logic                        mul_row, acc_row;
   logic signed [WORD_BITS-1:0] mul_a, mul_b, acc_bias;
   logic signed [65:0]          acc_sum;
   logic signed [49:0]          acc_shr;
   logic signed [WORD_BITS-1:0] acc_sat;

   always_comb begin
      mul_s   = cmd.cnt[3:0];
      mul_e   = mul_s[3:1];
      mul_row = (mul_e >= 3'd3);
      mul_col = mul_row ? 2'(mul_e - 3'd3) : mul_e[1:0];
      case ({mul_row, mul_s[0]})
         2'b00:   mul_a = m_ff[0];
         2'b01:   mul_a = m_ff[1];
         2'b10:   mul_a = m_ff[3];
         default: mul_a = m_ff[4];
      endcase
      case ({mul_s[0], mul_col})
         3'b000:  mul_b = b_ff[0];
         3'b001:  mul_b = b_ff[1];
         3'b010:  mul_b = b_ff[2];
         3'b100:  mul_b = b_ff[3];
         3'b101:  mul_b = b_ff[4];
         default: mul_b = b_ff[5];
      endcase

      acc_s    = mul_s - 4'd1;
      acc_e    = acc_s[3:1];
      acc_row  = (acc_e >= 3'd3);
      acc_col  = acc_row ? 2'(acc_e - 3'd3) : acc_e[1:0];
      acc_bias = acc_row ? m_ff[5] : m_ff[2];
      acc_sum  = acc_ff + 66'(prod_ff);
      acc_shr  = 50'(acc_sum >>> FRAC_BITS);
      if (acc_shr > 50'sd2147483647) begin
         acc_sat = 32'sh7fff_ffff;
      end else if (acc_shr < -50'sd2147483648) begin
         acc_sat = 32'sh8000_0000;
      end else begin
         acc_sat = WORD_BITS'(acc_shr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.load && req_data.kind == KIND_IDENT)) begin
         for (int k = 0; k < 6; k++) begin
            m_ff[k] <= (k == 0 || k == 4) ? ONE_Q : '0;
         end
      end else if (cmd.commit) begin
         for (int k = 0; k < 6; k++) begin
            m_ff[k] <= n_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int k = 0; k < 6; k++) begin
            b_ff[k] <= b_load[k];
         end
         r_ff <= {{2{req_data.angle_deg[31]}}, req_data.angle_deg} + RED_BIAS;
      end
      if (cmd.red_step && r_ff >= red_sub) begin
         r_ff <= r_ff - red_sub;
      end
      if (cmd.quad) begin
         q_ff <= quad_q;
         z_ff <= 25'(r_ff - quad_base);
         x_ff <= GAIN_Q30;
         y_ff <= '0;
      end
      if (cmd.cordic_step) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - cor_dx;
            y_ff <= y_ff + cor_dy;
            z_ff <= z_ff - cor_atan;
         end else begin
            x_ff <= x_ff + cor_dx;
            y_ff <= y_ff - cor_dy;
            z_ff <= z_ff + cor_atan;
         end
      end
      if (cmd.sincos) begin
         b_ff[0] <= rot_c;
         b_ff[1] <= -rot_s;
         b_ff[2] <= '0;
         b_ff[3] <= rot_s;
         b_ff[4] <= rot_c;
         b_ff[5] <= '0;
      end
      if (cmd.mult) begin
         if (cmd.cnt < MULT_LAST) begin
            prod_ff <= mul_a * mul_b;
         end
         if (cmd.cnt != '0) begin
            if (!acc_s[0]) begin
               // First term of an entry also carries the rounding offset and,
               // for the translation column, the entry's own offset term.
               acc_ff <= 66'(prod_ff) + 66'sd32768 +
                         ((acc_col == 2'd2) ? (66'(acc_bias) <<< FRAC_BITS) : 66'sd0);
            end else begin
               n_ff[acc_e] <= acc_sat;
            end
         end
      end
   end

   always_comb begin
      result.out_00 = m_ff[0];
      result.out_01 = m_ff[1];
      result.out_02 = m_ff[2];
      result.out_10 = m_ff[3];
      result.out_11 = m_ff[4];
      result.out_12 = m_ff[5];
      result.scale_or_rotate = (m_ff[0] != ONE_Q) || (m_ff[4] != ONE_Q) ||
                               (m_ff[1] != '0) || (m_ff[3] != '0);
   end

endmodule
`default_nettype wire

### rtl/core/affine_transform_composer.sv
// Top level of the affine transform composer.
//
//   port group   direction  payload   transaction
//   req_         in         req_type  one command
//   rsp_         out        rsp_type  running matrix after that command
//
// Identity and unused kinds go straight to the done state; scale, translate
// and matrix multiply run 12 products through one 32x32 multiplier; rotate
// first runs the 8-step angle reduction and the 20-step CORDIC.
// Reset loads the identity matrix. A result waiting in the output register
// does not block the next command; only a second finished result stalls.
`default_nettype none
module affine_transform_composer
   import atc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   ctl_cmd_type cmd;
   logic        idle, done, out_free;
   rsp_type     dp_result;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = idle;

   atc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .out_free  (out_free),
      .cmd       (cmd),
      .idle      (idle),
      .done      (done)
   );

   atc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .result   (dp_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= dp_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_done_only_when_free: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result finished while output register occupied");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff)
      else $error("finished result not presented");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction taken while busy");
`endif

endmodule
`default_nettype wire
